// ----- rtl/mvt_pkg.sv -----
// ----------------------------------------------------------------------------
// mvt_pkg: shared types and constants for the 4x4 matrix-vector transform
// Word, product and accumulator types, the matrix layout and register indexes.
// ----------------------------------------------------------------------------
package mvt_pkg;

  localparam int WORD_W            = 32;
  localparam int PROD_W            = 2 * WORD_W;
  localparam int PAIR_W            = PROD_W + 1;
  localparam int SUM_W             = PROD_W + 2;
  localparam int REG_W             = 64;
  localparam int NUM_REGS          = 8;
  localparam int REG_IDX_W         = $clog2(NUM_REGS);
  localparam int CFG_IDX_W         = 4;
  localparam int FRAC_BITS_DEFAULT = 16;

  // Register indexes: two registers per column, rows 0/1 then rows 2/3.
  localparam int REG_COL_X_R01 = 0;
  localparam int REG_COL_X_R23 = 1;
  localparam int REG_COL_Y_R01 = 2;
  localparam int REG_COL_Y_R23 = 3;
  localparam int REG_COL_Z_R01 = 4;
  localparam int REG_COL_Z_R23 = 5;
  localparam int REG_COL_W_R01 = 6;
  localparam int REG_COL_W_R23 = 7;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [REG_W-1:0]         cfg_word_t;
  typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

  // Four components of one vector, index 0 = x.
  typedef word_t [3:0] vec4_t;
  // Matrix entries indexed [column][row].
  typedef vec4_t [3:0] mat_t;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [PAIR_W-1:0] pair_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  // Products indexed column * 4 + row.
  typedef prod_t [15:0] prod_arr_t;
  // Partial sums indexed row * 2 + half (half 0: columns x,y; half 1: z,w).
  typedef pair_t [7:0]  pair_arr_t;
  typedef sum_t  [3:0]  row_arr_t;

endpackage

// ----- rtl/mvt_regs.sv -----
// ----------------------------------------------------------------------------
// mvt_regs: matrix configuration registers
// Eight 64-bit registers holding the matrix column-major, reset to identity.
// ----------------------------------------------------------------------------
module mvt_regs import mvt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  cfg_idx_t  cfg_index,
  input  cfg_word_t cfg_data,
  output mat_t      matrix
);

  localparam cfg_word_t ONE_LO = REG_W'(1) << FRAC_BITS;
  localparam cfg_word_t ONE_HI = ONE_LO << WORD_W;

  cfg_word_t regs [NUM_REGS];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs[REG_COL_X_R01] <= ONE_LO;
      regs[REG_COL_X_R23] <= '0;
      regs[REG_COL_Y_R01] <= ONE_HI;
      regs[REG_COL_Y_R23] <= '0;
      regs[REG_COL_Z_R01] <= '0;
      regs[REG_COL_Z_R23] <= ONE_LO;
      regs[REG_COL_W_R01] <= '0;
      regs[REG_COL_W_R23] <= ONE_HI;
    end else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_REGS))) begin
      regs[cfg_index[REG_IDX_W-1:0]] <= cfg_data;
    end
  end

  // Even rows sit in the low half of a register, odd rows in the high half.
  for (genvar c = 0; c < 4; c++) begin : g_col
    for (genvar r = 0; r < 4; r++) begin : g_row
      assign matrix[c][r] = regs[c * 2 + r / 2][(r % 2) * WORD_W +: WORD_W];
    end
  end

endmodule

// ----- rtl/mvt_mul.sv -----
// ----------------------------------------------------------------------------
// mvt_mul: multiply stage
// Sixteen 32x32 signed products of matrix entries and vector components.
// ----------------------------------------------------------------------------
module mvt_mul import mvt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  vec4_t     vec,
  input  mat_t      matrix,
  output logic      out_valid,
  input  logic      out_ready,
  output prod_arr_t prod
);

  prod_arr_t prod_next;

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        prod_next[c * 4 + r] = $signed(matrix[c][r]) * $signed(vec[c]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      prod <= prod_next;
    end
  end

endmodule

// ----- rtl/mvt_sum.sv -----
// ----------------------------------------------------------------------------
// mvt_sum: two-level adder tree
// First level adds product pairs per row, second level forms the row sums.
// ----------------------------------------------------------------------------
module mvt_sum import mvt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  prod_arr_t prod,
  output logic      out_valid,
  input  logic      out_ready,
  output row_arr_t  row_sum
);

  pair_arr_t pair;
  pair_arr_t pair_next;
  row_arr_t  row_sum_next;
  logic      pair_valid;
  logic      pair_ready;

  assign pair_ready = !out_valid || out_ready;
  assign in_ready   = !pair_valid || pair_ready;

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int h = 0; h < 2; h++) begin
        pair_next[r * 2 + h] = PAIR_W'(prod[(2 * h) * 4 + r])
                             + PAIR_W'(prod[(2 * h + 1) * 4 + r]);
      end
      row_sum_next[r] = SUM_W'(pair[r * 2]) + SUM_W'(pair[r * 2 + 1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pair_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        pair_valid <= in_valid;
      end
      if (pair_ready) begin
        out_valid <= pair_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      pair <= pair_next;
    end
    if (pair_valid && pair_ready) begin
      row_sum <= row_sum_next;
    end
  end

endmodule

// ----- rtl/mvt_round.sv -----
// ----------------------------------------------------------------------------
// mvt_round: rounding and saturation stage
// Rounds each row half up, drops the fraction bits and clamps to 32 bits.
// ----------------------------------------------------------------------------
module mvt_round import mvt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  row_arr_t row_sum,
  output logic     out_valid,
  input  logic     out_ready,
  output vec4_t    result,
  output logic     saturated
);

  localparam sum_t  HALF     = SUM_W'(1) << (FRAC_BITS - 1);
  localparam word_t WORD_MAX = {1'b0, {(WORD_W - 1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W - 1){1'b0}}};

  vec4_t result_next;
  logic  saturated_next;
  sum_t  rounded [4];
  sum_t  scaled  [4];

  assign in_ready = !out_valid || out_ready;

  always_comb begin
    saturated_next = 1'b0;
    for (int r = 0; r < 4; r++) begin
      rounded[r] = row_sum[r] + HALF;
      scaled[r]  = rounded[r] >>> FRAC_BITS;
      // The value fits when every bit above the word agrees with its sign.
      if ((scaled[r][SUM_W-1:WORD_W-1] == '0) || (scaled[r][SUM_W-1:WORD_W-1] == '1)) begin
        result_next[r] = scaled[r][WORD_W-1:0];
      end else begin
        result_next[r] = scaled[r][SUM_W-1] ? WORD_MIN : WORD_MAX;
        saturated_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      result    <= result_next;
      saturated <= saturated_next;
    end
  end

endmodule

// ----- rtl/mat4_vec4_transform.sv -----
// ----------------------------------------------------------------------------
// mat4_vec4_transform: 4x4 matrix times 4-vector transform, signed fixed point
// Streams vectors through a configured matrix at one transaction per cycle.
// ----------------------------------------------------------------------------
// Each accepted input transaction carries one vector (x, y, z, w) in signed
// fixed point with FRAC_BITS fraction bits, and produces exactly one output
// transaction holding the transformed vector and a saturation flag. The
// matrix lives in eight 64-bit configuration registers, column-major, with
// the even row of each pair in bits 31..0 and the odd row in bits 63..32;
// reset loads the identity. Writes with an index of eight or more are
// ignored. Every row is the exact sum of four full 64-bit products, rounded
// half toward plus infinity at the fraction point and clamped to 32 bits;
// any clamped row raises saturated. The datapath is a four-stage pipeline:
// sixteen 32x32 multipliers, a pairwise adder level, a row adder level, and
// a round-and-clamp output register. A new vector is taken every cycle while
// the output side accepts results, so throughput is one transaction per
// clock. A vector reaches the output once it has passed the product, pair,
// row-sum and result registers in turn. Each stage holds its item under
// backpressure and empty stages keep filling, so up to four transactions are
// in flight. Configuration writes are always accepted and must only be
// issued while the pipeline is empty.
// ----------------------------------------------------------------------------
module mat4_vec4_transform import mvt_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,

  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  cfg_idx_t  cfg_index,
  input  cfg_word_t cfg_data,

  input  logic      in_valid,
  output logic      in_ready,
  input  word_t     in_x,
  input  word_t     in_y,
  input  word_t     in_z,
  input  word_t     in_w,

  output logic      out_valid,
  input  logic      out_ready,
  output word_t     out_x,
  output word_t     out_y,
  output word_t     out_z,
  output word_t     out_w,
  output logic      saturated
);

  mat_t      matrix;
  vec4_t     vec;
  vec4_t     result;
  prod_arr_t prod;
  row_arr_t  row_sum;
  logic      mul_valid;
  logic      mul_ready;
  logic      sum_valid;
  logic      sum_ready;

  assign vec[0] = in_x;
  assign vec[1] = in_y;
  assign vec[2] = in_z;
  assign vec[3] = in_w;

  // The user must hold the matrix static while transactions are in flight
  // (not enforced by the block), so it feeds the multipliers directly, unstaged.
  mvt_regs #(
    .FRAC_BITS (FRAC_BITS)
  ) u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .matrix    (matrix)
  );

  // Stage 1: all sixteen products in parallel.
  mvt_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .vec       (vec),
    .matrix    (matrix),
    .out_valid (mul_valid),
    .out_ready (mul_ready),
    .prod      (prod)
  );

  // Stages 2 and 3: adder tree, one addition level per stage.
  mvt_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (mul_valid),
    .in_ready  (mul_ready),
    .prod      (prod),
    .out_valid (sum_valid),
    .out_ready (sum_ready),
    .row_sum   (row_sum)
  );

  // Stage 4: rounding, scaling and saturation into the output register.
  mvt_round #(
    .FRAC_BITS (FRAC_BITS)
  ) u_round (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sum_valid),
    .in_ready  (sum_ready),
    .row_sum   (row_sum),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .result    (result),
    .saturated (saturated)
  );

  assign out_x = result[0];
  assign out_y = result[1];
  assign out_z = result[2];
  assign out_w = result[3];

  localparam word_t WORD_MAX = {1'b0, {(WORD_W - 1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W - 1){1'b0}}};

  // The pipeline comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid right after reset");

  // Backpressure only originates at the output: the input can stall only
  // when a finished result is waiting there.
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without an output stall");

  // A saturated result has at least one component pinned at a bound.
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |->
      (out_x == WORD_MAX || out_x == WORD_MIN || out_y == WORD_MAX || out_y == WORD_MIN ||
       out_z == WORD_MAX || out_z == WORD_MIN || out_w == WORD_MAX || out_w == WORD_MIN))
    else $error("saturated flag without a clamped component");

endmodule
